@@ design/tlt_pkg.sv @@
// Shared types, token kinds and character constants for the tokenizer.
`default_nettype none

package tlt_pkg;

  localparam int unsigned MAX_WORD_CHARS_DEF = 8;
  localparam int unsigned NUMBER_BITS_DEF    = 32;
  localparam int unsigned FIFO_DEPTH_DEF     = 8;

  // Candidate token slots per byte and the most of them that can be valid at once.
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned MAX_PUSH  = 3;

  typedef enum logic [4:0] {
    TK_NUMBER = 5'd0,
    TK_IDENT  = 5'd1,
    TK_LET    = 5'd2,
    TK_IF     = 5'd3,
    TK_ELSE   = 5'd4,
    TK_WHILE  = 5'd5,
    TK_PRINT  = 5'd6,
    TK_PLUS   = 5'd7,
    TK_MINUS  = 5'd8,
    TK_MULT   = 5'd9,
    TK_DIV    = 5'd10,
    TK_EQUALS = 5'd11,
    TK_LT     = 5'd12,
    TK_GT     = 5'd13,
    TK_SEMI   = 5'd14,
    TK_LPAREN = 5'd15,
    TK_RPAREN = 5'd16,
    TK_LBRACE = 5'd17,
    TK_RBRACE = 5'd18,
    TK_END    = 5'd19
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [31:0] number;
    logic [63:0] text;
    logic [7:0]  length;
    logic        trunc;
    logic        last;
  } token_t;

  typedef struct packed {
    logic   [NUM_SLOTS-1:0] vld;
    token_t [NUM_SLOTS-1:0] tok;
  } push_t;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Keywords packed first letter in the low byte.
  localparam logic [63:0] KW_LET   = 64'h0000_0000_0074_656C;
  localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_ELSE  = 64'h0000_0000_6573_6C65;
  localparam logic [63:0] KW_WHILE = 64'h0000_0065_6C69_6877;
  localparam logic [63:0] KW_PRINT = 64'h0000_0074_6E69_7270;

  localparam logic [7:0] KW_LET_LEN   = 8'd3;
  localparam logic [7:0] KW_IF_LEN    = 8'd2;
  localparam logic [7:0] KW_ELSE_LEN  = 8'd4;
  localparam logic [7:0] KW_WHILE_LEN = 8'd5;
  localparam logic [7:0] KW_PRINT_LEN = 8'd5;

  localparam logic [7:0] LEN_MAX = 8'd255;

endpackage

`default_nettype wire

@@ design/tlt_fifo.sv @@
// Token buffer: takes up to three tokens per cycle, hands out one per cycle while popped.
`default_nettype none

module tlt_fifo
  import tlt_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   room_o,
  input  logic   pop_i,
  output logic   vld_o,
  output token_t head_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  token_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   offs [NUM_SLOTS];
  logic [PTR_W-1:0]   run;
  logic [CNT_W-1:0]   npush;

  always_comb begin
    run = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      offs[i] = run;
      if (push_i.vld[i]) begin
        run = run + PTR_W'(1);
      end
    end
    npush   = CNT_W'($countones(push_i.vld));
    tail_d  = tail_q + PTR_W'(npush);
    head_d  = pop_i ? head_q + PTR_W'(1) : head_q;
    count_d = count_q + npush - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (push_i.vld[i]) begin
        mem_q[tail_q + offs[i]] <= push_i.tok[i];
      end
    end
  end

  assign room_o = count_q <= CNT_W'(DEPTH - MAX_PUSH);
  assign vld_o  = count_q != '0;
  assign head_o = mem_q[head_q];

endmodule

`default_nettype wire

@@ design/toy_language_tokenizer.sv @@
// Top level of the streaming tokenizer: byte scanner and token output buffer.
`default_nettype none

// Takes one source byte per cycle into an input register; the scanner turns it into up to
// three tokens (pending number, word or slash, the byte's own operator, and on the final
// byte the flushed token and the end token) in the same cycle and writes them into an
// eight-entry token buffer, which hands out one token per cycle. A byte is accepted each
// cycle while the buffer has at least three free entries, so sustained input is one byte
// per cycle as long as the consumer keeps up; bursts of several tokens from one byte drain
// at one token per cycle. A token appears at the output once the byte that completes it has
// passed the input register and been written into the token buffer.
module toy_language_tokenizer
  import tlt_pkg::*;
#(
  parameter int unsigned MAX_WORD_CHARS = MAX_WORD_CHARS_DEF,
  parameter int unsigned NUMBER_BITS    = NUMBER_BITS_DEF,
  parameter int unsigned FIFO_DEPTH     = FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [31:0] number_value_o,
  output logic [63:0] word_text_o,
  output logic [7:0]  word_length_o,
  output logic        word_truncated_o,
  output logic        last_token_o
);

  localparam int unsigned BUF_W = MAX_WORD_CHARS * 8;
  localparam int unsigned NUM_W = NUMBER_BITS;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NUM     = 3'd1,
    MODE_WORD    = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_e;

  logic             in_vld_q;
  logic [7:0]       char_q;
  logic             eot_q;

  mode_e            mode_q, mode1;
  logic [NUM_W-1:0] acc_q, acc1;
  logic [BUF_W-1:0] buf_q, buf1;
  logic [7:0]       cnt_q, cnt1;
  logic             ovf_q, ovf1;

  logic             room;
  logic             fire;
  logic             is_digit, is_letter, op_hit, flush_old, start;
  tok_kind_e        op_kind;
  push_t            push;
  logic             fifo_vld;
  token_t           head;

  function automatic token_t flush_tok(mode_e m, logic [NUM_W-1:0] a, logic [BUF_W-1:0] b,
                                       logic [7:0] n, logic o);
    token_t      t;
    logic [63:0] aext;
    logic [63:0] bext;
    t      = '0;
    aext   = 64'(a);
    bext   = 64'(b);
    t.kind = TK_DIV;
    if (m == MODE_NUM) begin
      t.kind   = TK_NUMBER;
      t.number = aext[31:0];
    end else if (m == MODE_WORD) begin
      if (!o && n == KW_LET_LEN && bext == KW_LET) begin
        t.kind = TK_LET;
      end else if (!o && n == KW_IF_LEN && bext == KW_IF) begin
        t.kind = TK_IF;
      end else if (!o && n == KW_ELSE_LEN && bext == KW_ELSE) begin
        t.kind = TK_ELSE;
      end else if (!o && n == KW_WHILE_LEN && bext == KW_WHILE) begin
        t.kind = TK_WHILE;
      end else if (!o && n == KW_PRINT_LEN && bext == KW_PRINT) begin
        t.kind = TK_PRINT;
      end else begin
        t.kind   = TK_IDENT;
        t.text   = bext;
        t.length = n;
        t.trunc  = o;
      end
    end
    return t;
  endfunction

  assign in_ready_o = !in_vld_q || room;
  assign fire       = in_vld_q && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
      eot_q  <= end_of_text_i;
    end
  end

  always_comb begin
    is_digit  = char_q >= CH_0 && char_q <= CH_9;
    is_letter = (char_q >= CH_LC_A && char_q <= CH_LC_Z) ||
                (char_q >= CH_UC_A && char_q <= CH_UC_Z);
    op_hit  = 1'b1;
    op_kind = TK_PLUS;
    case (char_q)
      CH_PLUS:   op_kind = TK_PLUS;
      CH_MINUS:  op_kind = TK_MINUS;
      CH_STAR:   op_kind = TK_MULT;
      CH_EQUALS: op_kind = TK_EQUALS;
      CH_LT:     op_kind = TK_LT;
      CH_GT:     op_kind = TK_GT;
      CH_SEMI:   op_kind = TK_SEMI;
      CH_LPAREN: op_kind = TK_LPAREN;
      CH_RPAREN: op_kind = TK_RPAREN;
      CH_LBRACE: op_kind = TK_LBRACE;
      CH_RBRACE: op_kind = TK_RBRACE;
      default:   op_hit  = 1'b0;
    endcase
  end

  always_comb begin
    mode1     = mode_q;
    acc1      = acc_q;
    buf1      = buf_q;
    cnt1      = cnt_q;
    ovf1      = ovf_q;
    flush_old = 1'b0;
    start     = 1'b0;
    unique case (mode_q)
      MODE_NUM: begin
        if (is_digit) begin
          acc1 = (acc_q << 3) + (acc_q << 1) + NUM_W'(char_q[3:0]);
        end else begin
          flush_old = 1'b1;
          start     = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_letter) begin
          for (int i = 0; i < MAX_WORD_CHARS; i++) begin
            if (cnt_q == 8'(i)) begin
              buf1[i*8 +: 8] = char_q;
            end
          end
          ovf1 = ovf_q || (cnt_q >= 8'(MAX_WORD_CHARS));
          cnt1 = (cnt_q == LEN_MAX) ? cnt_q : cnt_q + 8'd1;
        end else begin
          flush_old = 1'b1;
          start     = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (char_q == CH_SLASH) begin
          mode1 = MODE_COMMENT;
        end else begin
          flush_old = 1'b1;
          start     = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (char_q == CH_NL) begin
          mode1 = MODE_IDLE;
        end
      end
      default: begin
        start = 1'b1;
      end
    endcase
    if (start) begin
      mode1 = MODE_IDLE;
      if (is_digit) begin
        mode1 = MODE_NUM;
        acc1  = NUM_W'(char_q[3:0]);
      end else if (is_letter) begin
        mode1 = MODE_WORD;
        buf1  = BUF_W'(char_q);
        cnt1  = 8'd1;
        ovf1  = 1'b0;
      end else if (char_q == CH_SLASH) begin
        mode1 = MODE_SLASH;
      end
    end
  end

  always_comb begin
    push            = '0;
    push.tok[0]     = flush_tok(mode_q, acc_q, buf_q, cnt_q, ovf_q);
    push.vld[0]     = fire && flush_old;
    push.tok[1]     = '0;
    push.tok[1].kind = op_kind;
    push.vld[1]     = fire && start && op_hit && !is_digit && !is_letter;
    push.tok[2]     = flush_tok(mode1, acc1, buf1, cnt1, ovf1);
    push.vld[2]     = fire && eot_q &&
                      (mode1 == MODE_NUM || mode1 == MODE_WORD || mode1 == MODE_SLASH);
    push.tok[3]      = '0;
    push.tok[3].kind = TK_END;
    push.tok[3].last = 1'b1;
    push.vld[3]      = fire && eot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      buf_q  <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (fire) begin
      if (eot_q) begin
        mode_q <= MODE_IDLE;
        acc_q  <= '0;
        buf_q  <= '0;
        cnt_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        mode_q <= mode1;
        acc_q  <= acc1;
        buf_q  <= buf1;
        cnt_q  <= cnt1;
        ovf_q  <= ovf1;
      end
    end
  end

  tlt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .pop_i  (fifo_vld && out_ready_i),
    .vld_o  (fifo_vld),
    .head_o (head)
  );

  assign out_valid_o      = fifo_vld;
  assign token_kind_o     = head.kind;
  assign number_value_o   = head.number;
  assign word_text_o      = head.text;
  assign word_length_o    = head.length;
  assign word_truncated_o = head.trunc;
  assign last_token_o     = head.last;

endmodule

`default_nettype wire

@@ bench/toy_language_tokenizer_tb.sv @@
// Self-checking testbench for the streaming tokenizer: source texts in, tokens checked.
`default_nettype none

module toy_language_tokenizer_tb
  import tlt_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT        = 400000;
  localparam int unsigned DRAIN_CYCLES       = 20;
  localparam int unsigned SOURCE_BYTES       = 170;
  localparam int unsigned LONG_WORD_LETTERS  = 20;
  localparam int unsigned HOLD_OFF_CYCLES    = 300;
  localparam int unsigned HOLD_OFF_AFTER     = 20;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_WORD,
    SCAN_SLASH,
    SCAN_COMMENT
  } scan_e;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } src_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code = '0;
  logic        end_of_text = 1'b0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [4:0]  token_kind_o;
  logic [31:0] number_value_o;
  logic [63:0] word_text_o;
  logic [7:0]  word_length_o;
  logic        word_truncated_o;
  logic        last_token_o;

  toy_language_tokenizer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code),
    .end_of_text_i    (end_of_text),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .token_kind_o     (token_kind_o),
    .number_value_o   (number_value_o),
    .word_text_o      (word_text_o),
    .word_length_o    (word_length_o),
    .word_truncated_o (word_truncated_o),
    .last_token_o     (last_token_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  int unsigned cycle_cnt = 0;
  logic        quiet_phase;
  assign quiet_phase = (cycle_cnt[7:6] == 2'b11);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Scanner state mirrored from the block
  scan_e       scan_mode = SCAN_IDLE;
  logic [31:0] number_acc = '0;
  logic [63:0] word_buf = '0;
  logic [7:0]  word_cnt = '0;
  logic        word_long = 1'b0;
  token_t      expected_tokens[$];

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic void push_token(tok_kind_e kind, logic [31:0] num, logic [63:0] text,
                                     logic [7:0] len, logic trunc, logic last);
    token_t t;
    t.kind   = kind;
    t.number = num;
    t.text   = text;
    t.length = len;
    t.trunc  = trunc;
    t.last   = last;
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function automatic void add_letter(logic [7:0] c);
    if (word_cnt < 8'(MAX_WORD_CHARS_DEF)) word_buf[8*word_cnt +: 8] = c;
    else word_long = 1'b1;
    if (word_cnt != LEN_MAX) word_cnt = word_cnt + 8'd1;
  endfunction

  function automatic void flush_word();
    tok_kind_e kind;
    kind = TK_IDENT;
    if (!word_long) begin
      if (word_cnt == KW_LET_LEN && word_buf == KW_LET) kind = TK_LET;
      else if (word_cnt == KW_IF_LEN && word_buf == KW_IF) kind = TK_IF;
      else if (word_cnt == KW_ELSE_LEN && word_buf == KW_ELSE) kind = TK_ELSE;
      else if (word_cnt == KW_WHILE_LEN && word_buf == KW_WHILE) kind = TK_WHILE;
      else if (word_cnt == KW_PRINT_LEN && word_buf == KW_PRINT) kind = TK_PRINT;
    end
    if (kind == TK_IDENT) push_token(TK_IDENT, '0, word_buf, word_cnt, word_long, 1'b0);
    else push_token(kind, '0, '0, '0, 1'b0, 1'b0);
    word_buf  = '0;
    word_cnt  = '0;
    word_long = 1'b0;
  endfunction

  function automatic void flush_pending();
    case (scan_mode)
      SCAN_NUMBER: begin
        push_token(TK_NUMBER, number_acc, '0, '0, 1'b0, 1'b0);
        number_acc = '0;
      end
      SCAN_WORD:  flush_word();
      SCAN_SLASH: push_token(TK_DIV, '0, '0, '0, 1'b0, 1'b0);
      default: ;
    endcase
    scan_mode = SCAN_IDLE;
  endfunction

  function automatic void start_byte(logic [7:0] c);
    tok_kind_e kind;
    bit        single;
    kind   = TK_END;
    single = 1'b1;
    if (is_digit(c)) begin
      scan_mode  = SCAN_NUMBER;
      number_acc = 32'(c - CH_0);
      single     = 1'b0;
    end else if (is_letter(c)) begin
      scan_mode = SCAN_WORD;
      word_buf  = '0;
      word_cnt  = '0;
      word_long = 1'b0;
      add_letter(c);
      single    = 1'b0;
    end else begin
      case (c)
        CH_SLASH: begin
          scan_mode = SCAN_SLASH;
          single    = 1'b0;
        end
        CH_PLUS:   kind = TK_PLUS;
        CH_MINUS:  kind = TK_MINUS;
        CH_STAR:   kind = TK_MULT;
        CH_EQUALS: kind = TK_EQUALS;
        CH_LT:     kind = TK_LT;
        CH_GT:     kind = TK_GT;
        CH_SEMI:   kind = TK_SEMI;
        CH_LPAREN: kind = TK_LPAREN;
        CH_RPAREN: kind = TK_RPAREN;
        CH_LBRACE: kind = TK_LBRACE;
        CH_RBRACE: kind = TK_RBRACE;
        default:   single = 1'b0;
      endcase
    end
    if (single) push_token(kind, '0, '0, '0, 1'b0, 1'b0);
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic last);
    case (scan_mode)
      SCAN_NUMBER: begin
        if (is_digit(c)) number_acc = number_acc * 32'd10 + 32'(c - CH_0);
        else begin
          flush_pending();
          start_byte(c);
        end
      end
      SCAN_WORD: begin
        if (is_letter(c)) add_letter(c);
        else begin
          flush_pending();
          start_byte(c);
        end
      end
      SCAN_SLASH: begin
        if (c == CH_SLASH) scan_mode = SCAN_COMMENT;
        else begin
          flush_pending();
          start_byte(c);
        end
      end
      SCAN_COMMENT: begin
        if (c == CH_NL) scan_mode = SCAN_IDLE;
      end
      default: start_byte(c);
    endcase
    if (last) begin
      flush_pending();
      push_token(TK_END, '0, '0, '0, 1'b0, 1'b1);
      scan_mode  = SCAN_IDLE;
      number_acc = '0;
      word_buf   = '0;
      word_cnt   = '0;
      word_long  = 1'b0;
    end
  endfunction

  // Source text construction
  src_byte_t   source_bytes[$];
  int unsigned bytes_total = 0;
  int unsigned bytes_taken = 0;

  function automatic void add_byte(logic [7:0] c);
    source_bytes.insert(source_bytes.size(), {c, 1'b0});
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
  endfunction

  function automatic void end_text();
    source_bytes[source_bytes.size()-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] any_letter();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(CH_LC_A, CH_LC_Z));
    return 8'($urandom_range(CH_UC_A, CH_UC_Z));
  endfunction

  function automatic void add_lexeme();
    string       keywords[5];
    string       ops;
    int unsigned pick;
    keywords = '{"let", "if", "else", "while", "print"};
    ops      = "+-*=<>;(){}";
    pick     = $urandom_range(0, 99);
    if (pick < 15) add_str(keywords[$urandom_range(0, 4)]);
    else if (pick < 30) begin
      repeat ($urandom_range(1, 12)) add_byte(any_letter());
    end else if (pick < 45) begin
      if ($urandom_range(0, 7) == 0) add_str($urandom_range(0, 1) ? "4294967295" : "4294967296");
      else repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(CH_0, CH_9)));
    end else if (pick < 70) add_byte(8'(ops[$urandom_range(0, ops.len()-1)]));
    else if (pick < 75) add_byte(CH_SLASH);
    else if (pick < 82) begin
      add_str("//");
      repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) add_byte(CH_NL);
    end else add_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 4))
      0, 1:    ;
      2:       add_byte(" ");
      3:       add_byte(CH_NL);
      default: add_byte(8'h09);
    endcase
  endfunction

  function automatic void add_every_token_text();
    string vocab[$];
    string tmp;
    int unsigned j;
    vocab = {"let", "if", "else", "while", "print", "abc", "42", "+", "-", "*", "=",
             "<", ">", ";", "(", ")", "{", "}", "/"};
    for (int i = vocab.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = vocab[i];
      vocab[i] = vocab[j];
      vocab[j] = tmp;
    end
    foreach (vocab[i]) begin
      add_str(vocab[i]);
      add_byte(" ");
    end
    end_text();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Byte driver
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : byte_driver
    src_byte_t item;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        tokenize_byte(char_code, end_of_text);
        bytes_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (source_bytes.size() != 0) begin
          item = source_bytes.pop_front();
          in_valid    <= 1'b1;
          char_code   <= item.code;
          end_of_text <= item.last;
          gap_left = quiet_phase ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Token monitor
  int unsigned mismatches = 0;
  int unsigned tokens_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_off_done = 1'b0;

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: token %0d %s expected %0h, got %0h", $time, tokens_seen, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : token_monitor
    token_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          $display("%0t: expected no token, got kind %0d", $time, token_kind_o);
        end else begin
          want = expected_tokens.pop_front();
          compare_field("token_kind", 64'(want.kind), 64'(token_kind_o));
          compare_field("number_value", 64'(want.number), 64'(number_value_o));
          compare_field("word_text", want.text, word_text_o);
          compare_field("word_length", 64'(want.length), 64'(word_length_o));
          compare_field("word_truncated", 64'(want.trunc), 64'(word_truncated_o));
          compare_field("last_token", 64'(want.last), 64'(last_token_o));
        end
        tokens_seen++;
      end
      // hold off once for long enough to fill the token buffer
      if (!hold_off_done && tokens_seen >= HOLD_OFF_AFTER) begin
        hold_off_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (quiet_phase || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold_left = pick_gap();
      end
    end
  end

  initial begin
    int unsigned goal;
    // lone slash, comment closed by newline, byte extremes, long word, slash at the end
    add_str("a/b//c\n");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str("whileelse 7/");
    end_text();
    // comment running into the end of text
    add_str("//x");
    end_text();
    repeat (LONG_WORD_LETTERS) add_byte(any_letter());
    add_byte(CH_SEMI);
    end_text();
    goal = SOURCE_BYTES;
    add_every_token_text();
    while (source_bytes.size() < goal) begin
      repeat ($urandom_range(2, 10)) add_lexeme();
      end_text();
    end
    bytes_total = source_bytes.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (bytes_taken != bytes_total) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
